>>> design/crv_pkg.sv
package crv_pkg;

   // Frame layout and format constants.
   localparam logic [31:0] RECORD_MAGIC   = 32'h504D_4346;
   localparam logic [31:0] MARKER_MAGIC   = 32'h504D_4143;
   localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
   localparam logic [15:0] HEADER_BYTES   = 16'd24;
   localparam logic [15:0] MARKER_BYTES   = 16'd20;
   localparam logic [14:0] PAYLOAD_LIMIT  = 15'd24576;
   localparam logic [15:0] FORMAT_VERSION = 16'd1;
   localparam logic [14:0] POS_MAX        = 15'h7FFF;
   localparam logic [7:0]  SLOT_A_CHAR    = 8'h61;
   localparam logic [7:0]  SLOT_B_CHAR    = 8'h62;

   // Register indexes on the configuration port.
   localparam logic REG_FRAME_MODE  = 1'b0;
   localparam logic REG_MAX_PAYLOAD = 1'b1;

   // Frame modes.
   localparam logic MODE_RECORD = 1'b0;
   localparam logic MODE_MARKER = 1'b1;

   typedef enum logic [3:0] {
      ST_OK       = 4'd0,
      ST_SHORT    = 4'd1,
      ST_MAGIC    = 4'd2,
      ST_VERSION  = 4'd3,
      ST_ZERO_GEN = 4'd4,
      ST_TOO_LONG = 4'd5,
      ST_SIZE     = 4'd6,
      ST_SLOT     = 4'd7,
      ST_CRC      = 4'd8
   } status_type;

   // Configuration handed from the register block to the core.
   typedef struct packed {
      logic        frame_mode;
      logic [14:0] max_payload_bytes;
   } cfg_type;

   // One result word.
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        payload_strobe;
      logic        frame_done;
      logic [3:0]  status;
      logic [63:0] generation;
      logic [14:0] body_length;
      logic        slot_id;
   } result_type;

   // Reflected CRC-32 over one byte, one bit per step.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

>>> design/crv_csr.sv
module crv_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output crv_pkg::cfg_type   cfg
);
   import crv_pkg::*;

   logic        frame_mode_ff;
   logic [14:0] max_payload_ff;
   logic        wr_en;
   logic        reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_sel = paddr[2];

   // Register writes during the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_mode_ff  <= MODE_RECORD;
         max_payload_ff <= PAYLOAD_LIMIT;
      end else if (wr_en) begin
         if (reg_sel == REG_FRAME_MODE) begin
            frame_mode_ff <= pwdata[0];
         end else begin
            max_payload_ff <= pwdata[14:0];
         end
      end
   end

   // Read data follows the address.
   always_comb begin
      if (reg_sel == REG_MAX_PAYLOAD) begin
         prdata = {17'd0, max_payload_ff};
      end else begin
         prdata = {31'd0, frame_mode_ff};
      end
   end

   assign cfg.frame_mode        = frame_mode_ff;
   assign cfg.max_payload_bytes = max_payload_ff;

endmodule

>>> design/crv_core.sv
module crv_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   input  crv_pkg::cfg_type     cfg,
   output crv_pkg::result_type  result
);
   import crv_pkg::*;

   // Frame state.
   logic [14:0] pos_ff,     pos_in;
   logic [31:0] crc_ff,     crc_in;
   logic [31:0] magic_ff,   magic_in;
   logic [15:0] version_ff, version_in;
   logic [63:0] gen_ff,     gen_in;
   logic [31:0] decl_ff,    decl_in;
   logic [31:0] stored_ff,  stored_in;
   logic [7:0]  slot_ff,    slot_in;

   // State after this word is captured, before any end-of-frame clear.
   logic [31:0] magic_nx, crc_nx, decl_nx, stored_nx;
   logic [15:0] version_nx;
   logic [63:0] gen_nx;
   logic [7:0]  slot_nx;

   logic        marker;
   logic        in_crc;
   logic        strobe;
   logic [15:0] size;
   logic [14:0] maxp;
   logic        too_long;
   logic        size_bad;
   status_type  status;

   assign marker = (cfg.frame_mode == MODE_MARKER);
   assign strobe = !marker && ({1'b0, pos_ff} >= HEADER_BYTES);

   // Field capture by byte position.
   always_comb begin
      magic_nx   = magic_ff;
      version_nx = version_ff;
      gen_nx     = gen_ff;
      decl_nx    = decl_ff;
      stored_nx  = stored_ff;
      slot_nx    = slot_ff;
      if (pos_ff < 15'd4) begin
         magic_nx[pos_ff[1:0]*8 +: 8] = data_byte;
      end else if (pos_ff == 15'd4) begin
         version_nx[7:0] = data_byte;
      end else if (pos_ff == 15'd5) begin
         version_nx[15:8] = data_byte;
      end else if (pos_ff == 15'd6 && marker) begin
         slot_nx = data_byte;
      end else if (pos_ff >= 15'd8 && pos_ff < 15'd16) begin
         gen_nx[pos_ff[2:0]*8 +: 8] = data_byte;
      end else if (pos_ff >= 15'd16 && pos_ff < 15'd20) begin
         if (marker) begin
            stored_nx[pos_ff[1:0]*8 +: 8] = data_byte;
         end else begin
            decl_nx[pos_ff[1:0]*8 +: 8] = data_byte;
         end
      end else if (pos_ff >= 15'd20 && pos_ff < 15'd24 && !marker) begin
         stored_nx[pos_ff[1:0]*8 +: 8] = data_byte;
      end
   end

   // CRC coverage depends on the mode of this word.
   always_comb begin
      if (marker) begin
         in_crc = (pos_ff == 15'd6) || (pos_ff >= 15'd8 && pos_ff < 15'd16);
      end else begin
         in_crc = (pos_ff >= 15'd8 && pos_ff < 15'd20) || (pos_ff >= 15'd24);
      end
      crc_nx = in_crc ? crc_byte(crc_ff, data_byte) : crc_ff;
   end

   // Verdict checks, first failure wins.
   assign size     = {1'b0, pos_ff} + 16'd1;
   assign maxp     = (cfg.max_payload_bytes > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT
                                                             : cfg.max_payload_bytes;
   assign too_long = decl_nx > {17'd0, maxp};
   assign size_bad = {17'd0, size} != ({17'd0, HEADER_BYTES} + {1'b0, decl_nx});

   always_comb begin
      if (marker) begin
         if (size < MARKER_BYTES)                  status = ST_SHORT;
         else if (size != MARKER_BYTES)            status = ST_SIZE;
         else if (magic_nx != MARKER_MAGIC)        status = ST_MAGIC;
         else if (version_nx != FORMAT_VERSION)    status = ST_VERSION;
         else if (gen_nx == 64'd0)                 status = ST_ZERO_GEN;
         else if (slot_nx != SLOT_A_CHAR && slot_nx != SLOT_B_CHAR) status = ST_SLOT;
         else if (~crc_nx != stored_nx)            status = ST_CRC;
         else                                      status = ST_OK;
      end else begin
         if (size < HEADER_BYTES)                  status = ST_SHORT;
         else if (magic_nx != RECORD_MAGIC)        status = ST_MAGIC;
         else if (version_nx != FORMAT_VERSION)    status = ST_VERSION;
         else if (gen_nx == 64'd0)                 status = ST_ZERO_GEN;
         else if (too_long)                        status = ST_TOO_LONG;
         else if (size_bad)                        status = ST_SIZE;
         else if (~crc_nx != stored_nx)            status = ST_CRC;
         else                                      status = ST_OK;
      end
   end

   // Result word for this byte.
   always_comb begin
      result.payload_byte   = strobe ? data_byte : 8'd0;
      result.payload_strobe = strobe;
      result.frame_done     = last_byte;
      result.status         = last_byte ? status : ST_OK;
      result.generation     = last_byte ? gen_nx : 64'd0;
      result.body_length    = (last_byte && !marker) ? (too_long ? maxp : decl_nx[14:0])
                                                     : 15'd0;
      result.slot_id        = last_byte && marker && (slot_nx == SLOT_B_CHAR);
   end

   // Next state: clear after the last byte, else keep captured fields and step the position.
   always_comb begin
      if (last_byte) begin
         pos_in     = 15'd0;
         crc_in     = CRC_INIT;
         magic_in   = 32'd0;
         version_in = 16'd0;
         gen_in     = 64'd0;
         decl_in    = 32'd0;
         stored_in  = 32'd0;
         slot_in    = 8'd0;
      end else begin
         pos_in     = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 15'd1;
         crc_in     = crc_nx;
         magic_in   = magic_nx;
         version_in = version_nx;
         gen_in     = gen_nx;
         decl_in    = decl_nx;
         stored_in  = stored_nx;
         slot_in    = slot_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 15'd0;
         crc_ff     <= CRC_INIT;
         magic_ff   <= 32'd0;
         version_ff <= 16'd0;
         gen_ff     <= 64'd0;
         decl_ff    <= 32'd0;
         stored_ff  <= 32'd0;
         slot_ff    <= 8'd0;
      end else if (advance) begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         magic_ff   <= magic_in;
         version_ff <= version_in;
         gen_ff     <= gen_in;
         decl_ff    <= decl_in;
         stored_ff  <= stored_in;
         slot_ff    <= slot_in;
      end
   end

   // A finished frame leaves the state ready for the next header.
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && last_byte) |=> (pos_ff == 15'd0 && crc_ff == CRC_INIT && gen_ff == 64'd0))
      else $error("frame state not cleared after last byte");

   // The byte count only moves while a word is processed.
   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pos_ff))
      else $error("byte position changed without a word");

   // Payload is only forwarded past the header of a data record.
   a_strobe_span: assert property (@(posedge clock) disable iff (reset)
      result.payload_strobe |-> (!marker && pos_ff >= 15'd24))
      else $error("payload strobe outside the record payload");

endmodule

>>> design/config_record_validator_top.sv
// Channel  Direction  Handshake            Word
// req      in         req_valid/req_stall  req_data_byte, req_last_byte
// rsp      out        rsp_valid/rsp_stall  rsp_payload_byte .. rsp_slot_id
// csr      in/out     psel/penable/pready  paddr, pwdata, prdata
//
// One byte is taken per cycle while rsp is not stalled; its result word is on rsp once it is in the result register.
// The path is an input register, the capture/CRC/verdict logic, and a result register.
// Synchronous reset clears the frame state, both valid flags and the configuration registers.
// A stall on rsp holds the result register; req stalls only once the input
// register is also full.
module config_record_validator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_strobe,
   output logic        rsp_frame_done,
   output logic [3:0]  rsp_status,
   output logic [63:0] rsp_generation,
   output logic [14:0] rsp_body_length,
   output logic        rsp_slot_id,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import crv_pkg::*;

   cfg_type     cfg;
   result_type  result;
   result_type  out_ff;
   logic        in_valid_ff, in_valid_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        advance;
   logic        req_take;

   crv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   crv_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .cfg       (cfg),
      .result    (result)
   );

   // Handshake: the input register moves on whenever the result register frees up.
   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input word register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_payload_strobe = out_ff.payload_strobe;
   assign rsp_frame_done     = out_ff.frame_done;
   assign rsp_status         = out_ff.status;
   assign rsp_generation     = out_ff.generation;
   assign rsp_body_length    = out_ff.body_length;
   assign rsp_slot_id        = out_ff.slot_id;

   // Verdict fields stay quiet on words that do not end a frame.
   a_mid_frame_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_done) |-> (rsp_status == ST_OK && rsp_generation == 64'd0
                                          && rsp_body_length == 15'd0 && !rsp_slot_id))
      else $error("verdict fields set on a word inside the frame");

   // Forwarded data is zero whenever the strobe is low.
   a_strobe_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload_strobe) |-> (rsp_payload_byte == 8'd0))
      else $error("payload byte set without strobe");

   // A word that the core processes shows up as a result next cycle.
   a_pipe_flow: assert property (@(posedge clock) disable iff (reset)
      (advance) |=> rsp_valid)
      else $error("processed word did not reach the result register");

endmodule

>>> tb/config_record_validator_top_tb.sv
module config_record_validator_top_tb;
   import crv_pkg::*;

   // Predicts the result word of every accepted byte and checks the words that come back.
   class verdict_board_type;
      bit          frame_mode;
      logic [14:0] max_payload;
      logic [14:0] position;
      logic [31:0] crc_acc;
      logic [31:0] magic_acc;
      logic [15:0] version_acc;
      logic [63:0] gen_acc;
      logic [31:0] length_acc;
      logic [31:0] crc_field;
      logic [7:0]  slot_acc;
      result_type  awaited[$];
      int          mismatches;
      int          words_seen;

      function new();
         frame_mode = MODE_RECORD;
         max_payload = PAYLOAD_LIMIT;
         mismatches = 0;
         words_seen = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         position = '0;
         crc_acc = '1;
         magic_acc = '0;
         version_acc = '0;
         gen_acc = '0;
         length_acc = '0;
         crc_field = '0;
         slot_acc = '0;
      endfunction

      // Reflected CRC-32, one input byte, shifting out the low bit first.
      static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
         logic [31:0] r;
         r = c ^ {24'd0, b};
         repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
         return r;
      endfunction

      // Capture the byte under the current mode and queue the word it must produce.
      function void note_byte(logic [7:0] b, logic last);
         result_type  w;
         int          p;
         bit          marker;
         bit          covered;
         int unsigned size;
         logic [14:0] lim;
         status_type  st;
         marker = (frame_mode == MODE_MARKER);
         p = position;
         if (p < 4) magic_acc[8*p +: 8] = b;
         else if (p < 6) version_acc[8*(p-4) +: 8] = b;
         else if (p == 6 && marker) slot_acc = b;
         else if (p >= 8 && p < 16) gen_acc[8*(p-8) +: 8] = b;
         else if (p >= 16 && p < 20) begin
            if (marker) crc_field[8*(p-16) +: 8] = b;
            else length_acc[8*(p-16) +: 8] = b;
         end else if (p >= 20 && p < 24 && !marker) crc_field[8*(p-20) +: 8] = b;

         covered = marker ? (p == 6 || (p >= 8 && p < 16)) : ((p >= 8 && p < 20) || p >= 24);
         if (covered) crc_acc = crc_step(crc_acc, b);

         w = '0;
         if (!marker && p >= HEADER_BYTES) begin
            w.payload_byte = b;
            w.payload_strobe = 1'b1;
         end
         w.frame_done = last;

         if (!last) begin
            // The position sticks at its top value on very long frames.
            if (position != POS_MAX) position = position + 1'b1;
         end else begin
            size = p + 1;
            lim = (max_payload > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : max_payload;
            if (marker) begin
               if (size < MARKER_BYTES) st = ST_SHORT;
               else if (size != MARKER_BYTES) st = ST_SIZE;
               else if (magic_acc != MARKER_MAGIC) st = ST_MAGIC;
               else if (version_acc != FORMAT_VERSION) st = ST_VERSION;
               else if (gen_acc == 0) st = ST_ZERO_GEN;
               else if (slot_acc != SLOT_A_CHAR && slot_acc != SLOT_B_CHAR) st = ST_SLOT;
               else if (~crc_acc != crc_field) st = ST_CRC;
               else st = ST_OK;
               w.slot_id = (slot_acc == SLOT_B_CHAR);
            end else begin
               if (size < HEADER_BYTES) st = ST_SHORT;
               else if (magic_acc != RECORD_MAGIC) st = ST_MAGIC;
               else if (version_acc != FORMAT_VERSION) st = ST_VERSION;
               else if (gen_acc == 0) st = ST_ZERO_GEN;
               else if (length_acc > lim) st = ST_TOO_LONG;
               else if (size != HEADER_BYTES + length_acc) st = ST_SIZE;
               else if (~crc_acc != crc_field) st = ST_CRC;
               else st = ST_OK;
               w.body_length = (length_acc > lim) ? lim : length_acc[14:0];
            end
            w.status = st;
            w.generation = gen_acc;
            clear_frame();
         end
         awaited = {awaited, w};
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         mismatches++;
      endtask

      task field_check(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report_mismatch($sformatf("word %0d %s: got %0h, expected %0h",
                                      words_seen, name, got, want));
      endtask

      // Compare an accepted result word with the oldest prediction.
      task check_word(result_type got);
         result_type want;
         words_seen++;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
            return;
         end
         want = awaited.pop_front();
         field_check("payload_byte", got.payload_byte, want.payload_byte);
         field_check("payload_strobe", got.payload_strobe, want.payload_strobe);
         field_check("frame_done", got.frame_done, want.frame_done);
         field_check("status", got.status, want.status);
         field_check("generation", got.generation, want.generation);
         field_check("body_length", got.body_length, want.body_length);
         field_check("slot_id", got.slot_id, want.slot_id);
      endtask
   endclass

   typedef enum int {
      FLAW_NONE, FLAW_MAGIC, FLAW_VERSION, FLAW_ZERO_GEN, FLAW_CRC,
      FLAW_TOO_LONG, FLAW_SIZE, FLAW_SHORT, FLAW_SLOT, FLAW_NOISE
   } flaw_type;

   localparam int QUIET_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_payload_strobe;
   logic        rsp_frame_done;
   logic [3:0]  rsp_status;
   logic [63:0] rsp_generation;
   logic [14:0] rsp_body_length;
   logic        rsp_slot_id;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   verdict_board_type sb;
   logic [7:0]   frame_bytes[$];
   bit           gaps_on = 1'b0;
   int           sent_bytes = 0;
   int           stall_left = 0;
   int           quiet_cycles = 0;

   config_record_validator_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_strobe (rsp_payload_strobe),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_status         (rsp_status),
      .rsp_generation     (rsp_generation),
      .rsp_body_length    (rsp_body_length),
      .rsp_slot_id        (rsp_slot_id),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Result side: check each accepted word, then, while gaps are on, stall for a random time.
   always @(posedge clock) begin : rsp_side
      result_type seen;
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.payload_byte = rsp_payload_byte;
            seen.payload_strobe = rsp_payload_strobe;
            seen.frame_done = rsp_frame_done;
            seen.status = rsp_status;
            seen.generation = rsp_generation;
            seen.body_length = rsp_body_length;
            seen.slot_id = rsp_slot_id;
            sb.check_word(seen);
            stall_left = gaps_on ? $urandom_range(0, 14) : 0;
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // Watchdog: the run ends when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Present one byte, after a random gap when gaps are on, and hold it until it is accepted.
   task automatic send_byte(logic [7:0] b, logic last);
      int gap;
      gap = gaps_on ? $urandom_range(0, 14) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(b, last);
      sent_bytes++;
   endtask

   task automatic send_range(int from, int upto);
      for (int i = from; i < upto; i++) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   task automatic send_whole();
      send_range(0, frame_bytes.size());
   endtask

   // Stop sending and wait until every predicted word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   // Register write followed by a read back, only once the block is idle.
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      logic [31:0] stored;
      drain();
      stored = (addr == {REG_FRAME_MODE, 2'b00}) ? (data & 32'h1) : (data & 32'h7FFF);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== stored)
         sb.report_mismatch($sformatf("register at %0d reads %0h, expected %0h",
                                      addr, prdata, stored));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mode(bit m);
      csr_write({REG_FRAME_MODE, 2'b00}, {31'd0, m});
      sb.frame_mode = m;
   endtask

   task automatic set_max(logic [31:0] v);
      csr_write({REG_MAX_PAYLOAD, 2'b00}, v);
      sb.max_payload = v[14:0];
   endtask

   // Append one byte to the frame under construction.
   function automatic void add_byte(logic [7:0] b);
      frame_bytes = {frame_bytes, b};
   endfunction

   // Data record: header with CRC over bytes 8..19 and the payload, then the payload.
   function automatic void build_record(logic [63:0] gen, logic [31:0] declared, int payload_n,
                                        logic [31:0] magic, logic [15:0] ver, bit bad_crc);
      logic [31:0] c;
      logic [7:0]  b;
      logic [7:0]  body[$];
      frame_bytes = {};
      for (int i = 0; i < 4; i++) add_byte(magic[8*i +: 8]);
      add_byte(ver[7:0]);
      add_byte(ver[15:8]);
      add_byte(8'($urandom));
      add_byte(8'($urandom));
      for (int i = 0; i < 8; i++) add_byte(gen[8*i +: 8]);
      for (int i = 0; i < 4; i++) add_byte(declared[8*i +: 8]);
      c = CRC_INIT;
      for (int i = 8; i < 20; i++) c = verdict_board_type::crc_step(c, frame_bytes[i]);
      for (int i = 0; i < payload_n; i++) begin
         b = 8'($urandom);
         body = {body, b};
         c = verdict_board_type::crc_step(c, b);
      end
      c = ~c;
      if (bad_crc) c = c ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++) add_byte(c[8*i +: 8]);
      foreach (body[i]) add_byte(body[i]);
   endfunction

   // Slot marker: CRC covers the slot byte and the generation.
   function automatic void build_marker(logic [63:0] gen, logic [7:0] slot,
                                        logic [31:0] magic, logic [15:0] ver, bit bad_crc);
      logic [31:0] c;
      frame_bytes = {};
      for (int i = 0; i < 4; i++) add_byte(magic[8*i +: 8]);
      add_byte(ver[7:0]);
      add_byte(ver[15:8]);
      add_byte(slot);
      add_byte(8'($urandom));
      c = verdict_board_type::crc_step(CRC_INIT, slot);
      for (int i = 0; i < 8; i++) begin
         add_byte(gen[8*i +: 8]);
         c = verdict_board_type::crc_step(c, gen[8*i +: 8]);
      end
      c = ~c;
      if (bad_crc) c = c ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++) add_byte(c[8*i +: 8]);
   endfunction

   // Half of the frames are well formed; the rest carry one flaw each.
   function automatic void build_random_frame();
      flaw_type    flaw;
      bit          marker;
      logic [63:0] gen;
      logic [31:0] magic;
      logic [15:0] ver;
      logic [31:0] declared;
      logic [7:0]  slot;
      logic [14:0] lim;
      int          n;
      int          cut;
      flaw = ($urandom_range(0, 1) == 0) ? FLAW_NONE : flaw_type'($urandom_range(1, 9));
      marker = (sb.frame_mode == MODE_MARKER);
      gen = {$urandom, $urandom};
      if (gen == 0) gen = 64'd1;
      if (flaw == FLAW_ZERO_GEN) gen = '0;
      magic = marker ? MARKER_MAGIC : RECORD_MAGIC;
      if (flaw == FLAW_MAGIC)
         magic = $urandom_range(0, 1) ? (magic ^ (32'd1 << $urandom_range(0, 31))) : $urandom;
      ver = FORMAT_VERSION;
      if (flaw == FLAW_VERSION) begin
         ver = 16'($urandom);
         if (ver == FORMAT_VERSION) ver = '0;
      end
      lim = (sb.max_payload > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : sb.max_payload;
      n = 0;

      if (marker) begin
         slot = $urandom_range(0, 1) ? SLOT_B_CHAR : SLOT_A_CHAR;
         if (flaw == FLAW_SLOT) begin
            do slot = 8'($urandom); while (slot == SLOT_A_CHAR || slot == SLOT_B_CHAR);
         end
         build_marker(gen, slot, magic, ver, flaw == FLAW_CRC);
      end else begin
         n = $urandom_range(0, (lim < 16) ? lim : 16);
         if ($urandom_range(0, 9) == 0 && lim > 16) n = $urandom_range(17, (lim < 80) ? lim : 80);
         declared = n;
         if (flaw == FLAW_TOO_LONG)
            declared = $urandom_range(0, 1) ? (lim + 1 + $urandom_range(0, 7))
                                            : ($urandom | 32'h0000_8000);
         build_record(gen, declared, n, magic, ver, flaw == FLAW_CRC);
      end

      // Frame size flaws: extra bytes past the end, or payload bytes missing.
      if (flaw == FLAW_SIZE || (flaw == FLAW_TOO_LONG && marker)) begin
         if (marker || n == 0 || $urandom_range(0, 1)) begin
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
         end else begin
            cut = $urandom_range(1, (n < 3) ? n : 3);
            repeat (cut) void'(frame_bytes.pop_back());
         end
      end
      if (flaw == FLAW_SHORT) begin
         cut = $urandom_range(1, (marker ? MARKER_BYTES : HEADER_BYTES) - 1);
         frame_bytes = frame_bytes[0:cut-1];
      end
      if (flaw == FLAW_NOISE) begin
         frame_bytes = {};
         repeat ($urandom_range(1, 40)) add_byte(8'($urandom));
      end
   endfunction

   initial begin
      logic [63:0] g;
      int          start;
      int          cut;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed record frames under the reset configuration.
      gaps_on = 1'b1;
      g = {$urandom, $urandom} | 64'd1;
      build_record(64'd1, 0, 0, RECORD_MAGIC, FORMAT_VERSION, 0);
      send_whole();
      build_record('1, 5, 5, RECORD_MAGIC, FORMAT_VERSION, 0);
      send_whole();
      build_record(g, 6, 6, RECORD_MAGIC ^ 32'h8000_0000, FORMAT_VERSION, 0);
      send_whole();
      build_record(g, 2, 2, RECORD_MAGIC, 16'h0100, 0);
      send_whole();
      build_record('0, 1, 1, RECORD_MAGIC, FORMAT_VERSION, 0);
      send_whole();
      build_record(g, 32'hFFFF_FFFF, 2, RECORD_MAGIC, FORMAT_VERSION, 0);
      send_whole();
      // Payload runs past the declared length: still forwarded, verdict is size.
      build_record(g, 3, 6, RECORD_MAGIC, FORMAT_VERSION, 0);
      send_whole();
      build_record(g, 4, 4, RECORD_MAGIC, FORMAT_VERSION, 1);
      send_whole();
      // Short frame that stops inside the generation field.
      build_record(g, 0, 0, RECORD_MAGIC, FORMAT_VERSION, 0);
      frame_bytes = frame_bytes[0:12];
      send_whole();
      frame_bytes = {8'h00};
      send_whole();

      // Zero maximum, then a maximum above the limit, which acts as the limit.
      set_max(0);
      build_record(g, 0, 0, RECORD_MAGIC, FORMAT_VERSION, 0);
      send_whole();
      build_record(g, 1, 1, RECORD_MAGIC, FORMAT_VERSION, 0);
      send_whole();
      set_max(32'h7FFF);
      build_record(g, PAYLOAD_LIMIT + 1, 0, RECORD_MAGIC, FORMAT_VERSION, 0);
      send_whole();
      set_max(PAYLOAD_LIMIT);

      // Directed marker frames.
      set_mode(MODE_MARKER);
      build_marker(g, SLOT_A_CHAR, MARKER_MAGIC, FORMAT_VERSION, 0);
      send_whole();
      build_marker('1, SLOT_B_CHAR, MARKER_MAGIC, FORMAT_VERSION, 0);
      send_whole();
      build_marker(g, 8'h63, MARKER_MAGIC, FORMAT_VERSION, 0);
      send_whole();
      build_marker(g, SLOT_A_CHAR, RECORD_MAGIC, FORMAT_VERSION, 0);
      send_whole();
      build_marker(g, SLOT_B_CHAR, MARKER_MAGIC, 16'd2, 0);
      send_whole();
      build_marker('0, SLOT_A_CHAR, MARKER_MAGIC, FORMAT_VERSION, 0);
      send_whole();
      build_marker(g, SLOT_B_CHAR, MARKER_MAGIC, FORMAT_VERSION, 1);
      send_whole();
      build_marker(g, SLOT_A_CHAR, MARKER_MAGIC, FORMAT_VERSION, 0);
      frame_bytes = frame_bytes[0:18];
      send_whole();
      build_marker(g, SLOT_A_CHAR, MARKER_MAGIC, FORMAT_VERSION, 0);
      add_byte(8'hFF);
      send_whole();

      // Mode switched in the middle of a frame.
      build_record(g, 3, 3, RECORD_MAGIC, FORMAT_VERSION, 0);
      send_range(0, 12);
      set_mode(MODE_RECORD);
      send_range(12, frame_bytes.size());

      // Random phases, each with its own mode, maximum and idling.
      start = sent_bytes;
      while (sent_bytes - start < 450) begin
         set_mode(1'($urandom_range(0, 1)));
         case ($urandom_range(0, 4))
            0: set_max(0);
            1: set_max(PAYLOAD_LIMIT);
            2: set_max(32'h7FFF);
            3: set_max($urandom_range(0, PAYLOAD_LIMIT));
            default: set_max($urandom_range(1, 40));
         endcase
         gaps_on = ($urandom_range(0, 3) != 0);
         repeat (6) begin
            build_random_frame();
            if ($urandom_range(0, 11) == 0 && frame_bytes.size() > 1) begin
               cut = $urandom_range(1, frame_bytes.size() - 1);
               send_range(0, cut);
               set_mode(~sb.frame_mode);
               send_range(cut, frame_bytes.size());
            end else begin
               send_whole();
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> sim.f
design/crv_pkg.sv
design/crv_csr.sv
design/crv_core.sv
design/config_record_validator_top.sv
tb/config_record_validator_top_tb.sv
